// ===== design/assert_macros.svh =====
// Assertion macros for the decoder RTL.
// Included by ucpd_core, the module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/ucpd_pkg.sv =====
// Package for the URI component percent decoder: widths, character codes,
// phase and status enums, result struct and small character classifiers.
`timescale 1ns / 1ps
`default_nettype none

package ucpd_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned FieldW = 12;
  localparam int unsigned NibW   = 4;

  localparam logic [FieldW-1:0] FIELD_MAX = '1;

  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
  localparam logic [CharW-1:0] CH_QUEST = 8'h3F;
  localparam logic [CharW-1:0] CH_HASH  = 8'h23;
  localparam logic [CharW-1:0] CH_PCT   = 8'h25;
  localparam logic [CharW-1:0] CH_TILDE = 8'h7E;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_DOT   = 8'h2E;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_HIGH,
    PH_LOW
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DOTDOT  = 2'd1,
    ST_BAD_ESC = 2'd2
  } status_e;

  typedef struct packed {
    logic              byte_valid;
    logic [CharW-1:0]  out_byte;
    logic [FieldW-1:0] dots_before;
    logic              done_res;
    status_e           status;
    logic [FieldW-1:0] warnings;
    logic [FieldW-1:0] consumed;
  } result_t;

  // {valid, nibble}
  function automatic logic [NibW:0] hex_decode(input logic [CharW-1:0] ch);
    logic [NibW:0] r;
    r = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, ch[NibW-1:0]};
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      r = {1'b1, NibW'(ch[NibW-1:0] + 4'd9)};
    end
    return r;
  endfunction

  function automatic logic is_reserved(input logic [CharW-1:0] ch);
    logic r;
    r = 1'b0;
    case (ch)
      8'h3A, 8'h5B, 8'h5D, 8'h40, 8'h21, 8'h24, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_stop(input logic [CharW-1:0] ch);
    return (ch == CH_NUL) || (ch == CH_SLASH) || (ch == CH_QUEST) || (ch == CH_HASH);
  endfunction

endpackage

`default_nettype wire

// ===== design/ucpd_if.sv =====
// Valid/ready stream interfaces for the decoder: raw character beats in,
// result beats out. Depends on ucpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ucpd_in_if;
  logic                        valid;
  logic                        ready;
  logic [ucpd_pkg::CharW-1:0]  char_in;
  logic                        is_last;

  modport source (output valid, char_in, is_last, input ready);
  modport sink   (input valid, char_in, is_last, output ready);
endinterface

interface ucpd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        byte_valid;
  logic [ucpd_pkg::CharW-1:0]  out_byte;
  logic [ucpd_pkg::FieldW-1:0] dots_before;
  logic                        done_res;
  ucpd_pkg::status_e           status;
  logic [ucpd_pkg::FieldW-1:0] warnings;
  logic [ucpd_pkg::FieldW-1:0] consumed;

  modport source (output valid, byte_valid, out_byte, dots_before, done_res, status,
                  warnings, consumed, input ready);
  modport sink   (input valid, byte_valid, out_byte, dots_before, done_res, status,
                  warnings, consumed, output ready);
endinterface

`default_nettype wire

// ===== design/ucpd_core.sv =====
// Input register, component state and single-pass decode logic.
// Depends on ucpd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ucpd_core #(
  parameter int unsigned MAX_LEN = 4095
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ucpd_pkg::CharW-1:0] in_char_i,
  input  logic                       in_last_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output ucpd_pkg::result_t          res_o
);

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);
  localparam logic [CntW-1:0] CNT_MAX = CntW'(MAX_LEN);

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
  endfunction

  function automatic logic [ucpd_pkg::FieldW-1:0] cap_field(input logic [CntW-1:0] v);
    return (32'(v) > 32'(ucpd_pkg::FIELD_MAX)) ? ucpd_pkg::FIELD_MAX
                                                : ucpd_pkg::FieldW'(v);
  endfunction

  // input register
  logic                       s1_valid_q;
  logic [ucpd_pkg::CharW-1:0] s1_char_q;
  logic                       s1_last_q;

  // component state
  ucpd_pkg::phase_e             phase_q, phase_d;
  logic [ucpd_pkg::NibW-1:0]    nib_q, nib_d;
  logic [CntW-1:0]              held_q, held_d;
  logic                         only_q, only_d;
  logic [ucpd_pkg::FieldW-1:0]  warn_q, warn_d;
  logic [CntW-1:0]              pos_q, pos_d;
  logic                         skip_q, skip_d;

  logic                         advance;
  logic [ucpd_pkg::NibW:0]      hex_c;
  logic                         have_byte;
  logic [ucpd_pkg::CharW-1:0]   dec_byte;
  logic                         done_c;
  logic                         err_c;
  logic                         emit_c;
  logic [CntW-1:0]              consumed_c;
  logic [CntW-1:0]              dots_c;
  ucpd_pkg::status_e            status_c;
  logic [ucpd_pkg::FieldW-1:0]  warn_out;

  always_comb begin
    phase_d    = phase_q;
    nib_d      = nib_q;
    held_d     = held_q;
    only_d     = only_q;
    warn_d     = warn_q;
    pos_d      = pos_q;
    skip_d     = skip_q;
    have_byte  = 1'b0;
    dec_byte   = '0;
    done_c     = 1'b0;
    err_c      = 1'b0;
    emit_c     = 1'b0;
    consumed_c = '0;
    dots_c     = '0;
    status_c   = ucpd_pkg::ST_OK;
    warn_out   = '0;
    hex_c      = ucpd_pkg::hex_decode(s1_char_q);

    if (skip_q) begin
      // drop beats up to the end of the abandoned component
      if (s1_last_q) begin
        skip_d = 1'b0;
      end
    end else begin
      unique case (phase_q)
        ucpd_pkg::PH_NONE: begin
          priority if (ucpd_pkg::is_stop(s1_char_q)) begin
            done_c     = 1'b1;
            consumed_c = pos_q;
          end else if (s1_char_q == ucpd_pkg::CH_PCT) begin
            if (s1_last_q) begin
              err_c      = 1'b1;
              consumed_c = pos_q;
            end else begin
              phase_d = ucpd_pkg::PH_HIGH;
            end
          end else begin
            if (ucpd_pkg::is_reserved(s1_char_q) || s1_char_q <= ucpd_pkg::CH_SPACE ||
                s1_char_q > ucpd_pkg::CH_TILDE) begin
              warn_d = (warn_q != ucpd_pkg::FIELD_MAX) ? warn_q + 1'b1 : warn_q;
            end
            have_byte = 1'b1;
            dec_byte  = s1_char_q;
          end
        end
        ucpd_pkg::PH_HIGH: begin
          consumed_c = (pos_q >= CntW'(1)) ? pos_q - CntW'(1) : '0;
          if (!hex_c[ucpd_pkg::NibW] || s1_last_q) begin
            err_c = 1'b1;
          end else begin
            nib_d   = hex_c[ucpd_pkg::NibW-1:0];
            phase_d = ucpd_pkg::PH_LOW;
          end
        end
        ucpd_pkg::PH_LOW: begin
          consumed_c = (pos_q >= CntW'(2)) ? pos_q - CntW'(2) : '0;
          if (!hex_c[ucpd_pkg::NibW]) begin
            err_c = 1'b1;
          end else begin
            dec_byte  = {nib_q, hex_c[ucpd_pkg::NibW-1:0]};
            have_byte = 1'b1;
            phase_d   = ucpd_pkg::PH_NONE;
          end
        end
        default: begin
          phase_d = ucpd_pkg::PH_NONE;
        end
      endcase

      // hold leading dots until the component shows a non-dot byte
      if (have_byte) begin
        if (only_q && dec_byte == ucpd_pkg::CH_DOT) begin
          held_d    = sat_inc(held_q);
          have_byte = 1'b0;
        end else begin
          emit_c = 1'b1;
          dots_c = held_q;
          held_d = '0;
          only_d = 1'b0;
        end
      end

      if (!done_c && !err_c && s1_last_q) begin
        consumed_c = sat_inc(pos_q);
      end
      pos_d = sat_inc(pos_q);

      if (err_c) begin
        done_c   = 1'b1;
        status_c = ucpd_pkg::ST_BAD_ESC;
      end

      if (done_c || s1_last_q) begin
        done_c = 1'b1;
        if (only_d) begin
          if (held_d == CntW'(2)) begin
            status_c = ucpd_pkg::ST_DOTDOT;
          end
          dots_c = (held_d >= CntW'(3)) ? held_d - CntW'(3) : '0;
        end
        warn_out = warn_d;
        skip_d   = !s1_last_q;
        emit_c   = 1'b1;
        phase_d  = ucpd_pkg::PH_NONE;
        nib_d    = '0;
        held_d   = '0;
        only_d   = 1'b1;
        warn_d   = '0;
        pos_d    = '0;
      end
    end
  end

  assign res_valid_o = s1_valid_q && emit_c;
  assign advance     = s1_valid_q && (res_ready_i || !emit_c);
  assign in_ready_o  = !s1_valid_q || advance;

  always_comb begin
    res_o.byte_valid  = have_byte;
    res_o.out_byte    = have_byte ? dec_byte : '0;
    res_o.dots_before = cap_field(dots_c);
    res_o.done_res    = done_c;
    res_o.status      = status_c;
    res_o.warnings    = warn_out;
    res_o.consumed    = done_c ? cap_field(consumed_c) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_char_q <= in_char_i;
      s1_last_q <= in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ucpd_pkg::PH_NONE;
      nib_q   <= '0;
      held_q  <= '0;
      only_q  <= 1'b1;
      warn_q  <= '0;
      pos_q   <= '0;
      skip_q  <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
      held_q  <= held_d;
      only_q  <= only_d;
      warn_q  <= warn_d;
      pos_q   <= pos_d;
      skip_q  <= skip_d;
    end
  end

  `ASSERT_CLK(a_skip_no_escape, skip_q |-> (phase_q == ucpd_pkg::PH_NONE), "escape pending while skipping")
  `ASSERT_CLK(a_dots_only_held, !only_q |-> (held_q == '0), "dots held after a non-dot byte")
  `ASSERT_CLK(a_mid_result_has_byte, (res_valid_o && !res_o.done_res) |-> res_o.byte_valid, "empty result mid-component")

endmodule

`default_nettype wire

// ===== design/ucpd_out_reg.sv =====
// Result register between the decode logic and the output channel.
// Depends on ucpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucpd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  output logic              res_ready_o,
  input  ucpd_pkg::result_t res_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ucpd_pkg::result_t out_o
);

  logic              valid_q;
  ucpd_pkg::result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/uri_component_percent_decoder.sv =====
// URI component percent decoder, top level.
// Channels: in_i takes one raw character beat (char_in, is_last) per handshake;
//   out_o gives at most one result beat per input beat.
// Each beat decodes %XY escapes, counts warnings for plain reserved or
//   non-printable characters and holds leading dots back; the beat that ends
//   a component carries done_res, status, warnings and consumed.
// Path: a result beat passes through the input register and then the result
//   register before it is valid on out_o.
// Throughput: one beat per cycle unless out_o stalls; the decode state update
//   is a single pass of short logic between the input and result registers.
// Beats that produce no result (held dots, first escape digits, skipped tail
//   after a stop) leave the pipeline without a result beat.
// Reset: clears all beats in flight and returns to the start of a component.
// Stall: while out_o is held, the result register keeps its beat; beats that
//   give no result still pass through the input register, and in_i.ready
//   drops once the input register holds a beat that has a result.
// MAX_LEN: saturation point of the position and held-dot counters.
`timescale 1ns / 1ps
`default_nettype none

module uri_component_percent_decoder #(
  parameter int unsigned MAX_LEN = 4095
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ucpd_in_if.sink    in_i,
  ucpd_out_if.source out_o
);

  logic              res_valid;
  logic              res_ready;
  ucpd_pkg::result_t res;
  ucpd_pkg::result_t out_data;

  // decode each beat against the component state
  ucpd_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_char_i   (in_i.char_in),
    .in_last_i   (in_i.is_last),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // hold the result beat until the sink takes it
  ucpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_data)
  );

  assign out_o.byte_valid  = out_data.byte_valid;
  assign out_o.out_byte    = out_data.out_byte;
  assign out_o.dots_before = out_data.dots_before;
  assign out_o.done_res    = out_data.done_res;
  assign out_o.status      = out_data.status;
  assign out_o.warnings    = out_data.warnings;
  assign out_o.consumed    = out_data.consumed;

endmodule

`default_nettype wire

// ===== test/uri_component_percent_decoder_test.sv =====
// Self-checking bench for uri_component_percent_decoder: directed and random
// escaped components checked against a built-in decoder prediction.
// Depends on ucpd_pkg, ucpd_in_if / ucpd_out_if and the decoder RTL.
`timescale 1ns / 1ps

module uri_component_percent_decoder_test;
  import ucpd_pkg::*;

  localparam int unsigned MAX_LEN        = 4095;
  localparam int unsigned IDLE_PCT       = 21;
  localparam int unsigned RANDOM_ITEMS   = 360;
  localparam int unsigned LONG_RUN       = 40;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned PRINT_LIMIT    = 40;
  localparam int unsigned SETTLE_CYCLES  = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  ucpd_in_if  in_if ();
  ucpd_out_if out_if ();

  uri_component_percent_decoder #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decoder state as the bench tracks it; a single copy, restarted at each component end.
  phase_e             esc_phase;
  logic [NibW-1:0]    esc_high;
  logic [FieldW-1:0]  dot_run;
  bit                 dots_only;
  logic [FieldW-1:0]  warn_count;
  logic [FieldW-1:0]  char_pos;
  bit                 skip_tail;

  result_t     pending_decodes[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned items_sent     = 0;
  int unsigned stall_cycles   = 0;
  bit          steady_flow    = 1'b0;

  function automatic int hex_nibble(input logic [CharW-1:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
    if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
    if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
    return -1;
  endfunction

  function automatic logic [CharW-1:0] hex_char(input logic [NibW-1:0] nib, input bit upper);
    if (nib < 10) return 8'h30 + nib;
    return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  function automatic logic [FieldW-1:0] count_up(input logic [FieldW-1:0] v);
    return (v < MAX_LEN) ? v + 1'b1 : FieldW'(MAX_LEN);
  endfunction

  function automatic void restart_component();
    esc_phase  = PH_NONE;
    esc_high   = '0;
    dot_run    = '0;
    dots_only  = 1'b1;
    warn_count = '0;
    char_pos   = '0;
  endfunction

  // Advance the tracked state by one character; return 1 when the beat
  // leaves a result, which is then placed in res.
  function automatic bit decode_char(input logic [CharW-1:0] ch, input bit last,
                                     output result_t res);
    bit                have_byte;
    bit                emit;
    bit                done;
    bit                bad;
    bit                plain_warn;
    logic [CharW-1:0]  dec_byte;
    logic [FieldW-1:0] dots;
    logic [FieldW-1:0] used;
    status_e           st;
    int                nib;
    res       = '0;
    have_byte = 1'b0;
    emit      = 1'b0;
    done      = 1'b0;
    bad       = 1'b0;
    dec_byte  = '0;
    dots      = '0;
    used      = '0;
    st        = ST_OK;
    // Drop everything after a stop up to the end of the component.
    if (skip_tail) begin
      if (last) skip_tail = 1'b0;
      return 1'b0;
    end
    case (esc_phase)
      PH_NONE: begin
        if (ch == CH_NUL || ch == CH_SLASH || ch == CH_QUEST || ch == CH_HASH) begin
          done = 1'b1;
          used = char_pos;
        end else if (ch == CH_PCT) begin
          if (last) begin
            bad  = 1'b1;
            used = char_pos;
          end else begin
            esc_phase = PH_HIGH;
          end
        end else begin
          case (ch)
            ":", "[", "]", "@", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=":
              plain_warn = 1'b1;
            default: plain_warn = (ch <= CH_SPACE) || (ch > CH_TILDE);
          endcase
          if (plain_warn) warn_count = count_up(warn_count);
          have_byte = 1'b1;
          dec_byte  = ch;
        end
      end
      PH_HIGH: begin
        nib  = hex_nibble(ch);
        used = (char_pos >= 1) ? char_pos - 1'b1 : '0;
        if (nib < 0 || last) begin
          bad = 1'b1;
        end else begin
          esc_high  = nib[NibW-1:0];
          esc_phase = PH_LOW;
        end
      end
      default: begin
        nib  = hex_nibble(ch);
        used = (char_pos >= 2) ? char_pos - 2'd2 : '0;
        if (nib < 0) begin
          bad = 1'b1;
        end else begin
          dec_byte  = {esc_high, nib[NibW-1:0]};
          have_byte = 1'b1;
          esc_phase = PH_NONE;
        end
      end
    endcase
    // Hold leading dots back; release them in front of the first other byte.
    if (have_byte) begin
      if (dots_only && dec_byte == CH_DOT) begin
        dot_run   = count_up(dot_run);
        have_byte = 1'b0;
      end else begin
        emit      = 1'b1;
        dots      = dot_run;
        dot_run   = '0;
        dots_only = 1'b0;
      end
    end
    if (!done && !bad && last) used = count_up(char_pos);
    char_pos = count_up(char_pos);
    if (bad) begin
      done = 1'b1;
      st   = ST_BAD_ESC;
    end
    if (done || last) begin
      // An all-dot component loses three dots; exactly two marks dot-dot.
      if (dots_only) begin
        if (dot_run == 2) st = ST_DOTDOT;
        dots = (dot_run >= 3) ? dot_run - 2'd3 : '0;
      end
      res.done_res = 1'b1;
      res.status   = st;
      res.warnings = warn_count;
      res.consumed = used;
      skip_tail    = !last;
      restart_component();
      emit = 1'b1;
    end
    if (!emit) return 1'b0;
    res.byte_valid  = have_byte;
    res.out_byte    = have_byte ? dec_byte : '0;
    res.dots_before = dots;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] result %0d: %s got %0d want %0d", $time, results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Check every result beat against the oldest prediction, then predict for
  // the input beat taken at this edge. Both sides are sampled before any
  // update of this edge lands.
  always @(posedge clk_i) begin : result_check
    result_t want;
    bit      in_beat;
    bit      out_beat;
    if (rst_ni) begin
      in_beat  = in_if.valid && in_if.ready;
      out_beat = out_if.valid && out_if.ready;
      if (out_beat) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch("result with none expected", 1, 0);
        end else begin
          want = pending_decodes.pop_front();
          if (out_if.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", out_if.byte_valid, want.byte_valid);
          if (out_if.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_if.out_byte, want.out_byte);
          if (out_if.dots_before !== want.dots_before)
            report_mismatch("dots_before", out_if.dots_before, want.dots_before);
          if (out_if.done_res !== want.done_res)
            report_mismatch("done_res", out_if.done_res, want.done_res);
          if (out_if.status !== want.status)
            report_mismatch("status", out_if.status, want.status);
          if (out_if.warnings !== want.warnings)
            report_mismatch("warnings", out_if.warnings, want.warnings);
          if (out_if.consumed !== want.consumed)
            report_mismatch("consumed", out_if.consumed, want.consumed);
        end
        results_seen++;
      end
      if (in_beat && decode_char(in_if.char_in, in_if.is_last, want))
        pending_decodes.push_back(want);
      stall_cycles = (in_beat || out_beat) ? 0 : stall_cycles + 1;
    end
  end

  // Stall the result side at random unless a steady stretch is running.
  always @(posedge clk_i) begin
    out_if.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // End the run if nothing moves for far longer than any correct stall.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Offer one character beat and hold it until the decoder takes it. Valid
  // stays high into the next beat, so back-to-back beats need no gap.
  task automatic send_char(input logic [CharW-1:0] ch, input bit last);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.char_in <= ch;
    in_if.is_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Drop valid and hold off until every predicted result has come out.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_decodes.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_escapes();
    send_text("a%41%fF");
    send_text("%4");
    send_text("%");
    send_text("%g");
    send_text("%4z");
  endtask

  task automatic test_stops_and_warnings();
    send_text("b/c");
    send_char(CH_NUL, 1'b1);
    send_char(CH_QUEST, 1'b1);
    send_char(CH_HASH, 1'b1);
    send_char(CH_SPACE, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_dot_components();
    send_text("....");
    // Decoded and plain dot make two; the bad escape still reads as dot-dot.
    send_text("%2E.%zz");
  endtask

  // Long components of warnings and dots sent back to back; run with no
  // idling on either side.
  task automatic test_long_components();
    steady_flow = 1'b1;
    for (int i = 0; i < LONG_RUN; i++) send_char(CH_SPACE, i == LONG_RUN - 1);
    for (int i = 0; i < LONG_RUN; i++) send_char(CH_DOT, 1'b0);
    send_char("q", 1'b1);
    for (int i = 0; i < LONG_RUN; i++) send_char(CH_DOT, i == LONG_RUN - 1);
    steady_flow = 1'b0;
  endtask

  // Build one component from weighted pieces: mostly plain text, escapes and
  // dots, with warning characters, stops, bad escapes and raw noise mixed in.
  task automatic send_random_component();
    logic [CharW-1:0] chars[$];
    string            marks;
    int unsigned      pieces;
    int unsigned      pick;
    logic [CharW-1:0] ch;
    marks  = ":[]@!$&'()*+,;= ";
    pieces = $urandom_range(1, 10);
    if ($urandom_range(0, 4) == 0) begin
      // Dot-only lead, some dots escaped, sometimes followed by one piece.
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 3) == 0) begin
          chars.push_back(CH_PCT);
          chars.push_back("2");
          chars.push_back(hex_char(4'hE, 1'($urandom_range(0, 1))));
        end else begin
          chars.push_back(CH_DOT);
        end
      end
      pieces = $urandom_range(0, 1);
    end
    repeat (pieces) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        ch = CharW'($urandom_range(8'h21, 8'h7E));
        if (ch == CH_PCT || ch == CH_SLASH || ch == CH_QUEST || ch == CH_HASH) ch = "z";
        chars.push_back(ch);
      end else if (pick < 55) begin
        ch = CharW'($urandom_range(0, 255));
        chars.push_back(CH_PCT);
        chars.push_back(hex_char(ch[7:4], 1'($urandom_range(0, 1))));
        chars.push_back(hex_char(ch[3:0], 1'($urandom_range(0, 1))));
      end else if (pick < 63) begin
        chars.push_back(CH_DOT);
      end else if (pick < 73) begin
        case ($urandom_range(0, 2))
          0: chars.push_back(marks[$urandom_range(0, marks.len() - 1)]);
          1: chars.push_back(CharW'($urandom_range(1, 8'h1F)));
          default: chars.push_back(CharW'($urandom_range(8'h7F, 8'hFF)));
        endcase
      end else if (pick < 78) begin
        chars.push_back(CH_PCT);
        if ($urandom_range(0, 1))
          chars.push_back(hex_char(NibW'($urandom_range(0, 15)), 1'b1));
        chars.push_back(CharW'($urandom_range(8'h67, 8'h7A)));
      end else if (pick < 84) begin
        case ($urandom_range(0, 3))
          0: chars.push_back(CH_NUL);
          1: chars.push_back(CH_SLASH);
          2: chars.push_back(CH_QUEST);
          default: chars.push_back(CH_HASH);
        endcase
      end else begin
        chars.push_back(CharW'($urandom_range(0, 255)));
      end
    end
    // Now and then cut the component off inside an escape.
    if ($urandom_range(0, 14) == 0) begin
      chars.push_back(CH_PCT);
      if ($urandom_range(0, 1))
        chars.push_back(hex_char(NibW'($urandom_range(0, 15)), 1'b0));
    end
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic test_random_components();
    int unsigned start;
    bit          paused;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < RANDOM_ITEMS) begin
      send_random_component();
      // Once, midway, let the decoder run completely dry before going on.
      if (!paused && items_sent - start >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.char_in  <= '0;
    in_if.is_last  <= 1'b0;
    skip_tail      = 1'b0;
    restart_component();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_escapes();
    test_stops_and_warnings();
    test_dot_components();
    test_long_components();
    test_random_components();

    // Let the last results out, then allow for the two-stage pipeline.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_decodes.size() != 0)
      report_mismatch("results never produced", 0, pending_decodes.size());
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
